// ----- hw/rtl/swsu_pkg.sv -----
// Shared types, register map and duty patterns for the square wave sound unit.
package swsu_pkg;

  localparam int unsigned WAVE_BYTES = 16;
  localparam int unsigned WAVE_AW    = $clog2(WAVE_BYTES);
  localparam int unsigned NUM_REGS   = 16;
  localparam int unsigned REG_AW     = $clog2(NUM_REGS);
  localparam int unsigned NUM_SQ     = 2;
  localparam int unsigned FREQ_W     = 11;
  localparam int unsigned LEVEL_W    = 14;

  localparam logic [FREQ_W-1:0]  PERIOD_TOP = 11'd2047;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 14'd10000;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = 14'd5000;
  localparam logic [7:0]         SAMPLE_PERIOD_RST = 8'd23;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  // Register addresses (low byte)
  localparam logic [7:0] ADDR_NR10    = 8'h10;
  localparam logic [7:0] ADDR_NR11    = 8'h11;
  localparam logic [7:0] ADDR_NR12    = 8'h12;
  localparam logic [7:0] ADDR_NR14    = 8'h14;
  localparam logic [7:0] ADDR_NR21    = 8'h16;
  localparam logic [7:0] ADDR_NR22    = 8'h17;
  localparam logic [7:0] ADDR_NR24    = 8'h19;
  localparam logic [7:0] ADDR_NR30    = 8'h1A;
  localparam logic [7:0] ADDR_NR31    = 8'h1B;
  localparam logic [7:0] ADDR_NR32    = 8'h1C;
  localparam logic [7:0] ADDR_NR34    = 8'h1E;
  localparam logic [7:0] ADDR_NR41    = 8'h20;
  localparam logic [7:0] ADDR_NR42    = 8'h21;
  localparam logic [7:0] ADDR_NR43    = 8'h22;
  localparam logic [7:0] ADDR_NR44    = 8'h23;
  localparam logic [7:0] ADDR_NR50    = 8'h24;
  localparam logic [7:0] ADDR_NR51    = 8'h25;
  localparam logic [7:0] ADDR_NR52    = 8'h26;
  localparam logic [7:0] ADDR_WAVE_LO = 8'h30;
  localparam logic [7:0] ADDR_WAVE_HI = 8'h3F;

  // Read masks
  localparam logic [7:0] MASK_NR10   = 8'h80;
  localparam logic [7:0] MASK_NRX1   = 8'h3F;
  localparam logic [7:0] MASK_NR30   = 8'h7F;
  localparam logic [7:0] MASK_NR32   = 8'h9F;
  localparam logic [7:0] MASK_NRX4   = 8'hBF;
  localparam logic [7:0] MASK_NR52   = 8'h70;
  localparam logic [7:0] READ_UNMAP  = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] address;
    logic [7:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic              step;
    logic [FREQ_W-1:0] freq;
  } sq_ctrl_t;

  typedef struct packed {
    logic       on;
    logic [1:0] duty;
  } sq_mix_t;

  typedef struct packed {
    logic              hit;
    logic [REG_AW-1:0] idx;
  } chan_sel_t;

  // Bit n of each row is the level at duty position n
  localparam logic [7:0] DUTY_TABLE [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
    logic [7:0] row;
    row = DUTY_TABLE[duty];
    return row[pos];
  endfunction

  // Map a channel register address to its slot in the channel register file
  function automatic chan_sel_t chan_decode(input logic [7:0] addr);
    chan_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = '0;
    case (addr) inside
      [8'h11:8'h14]: sel.idx = REG_AW'(addr - 8'h11);
      [8'h16:8'h19]: sel.idx = REG_AW'(addr - 8'h12);
      [8'h1B:8'h1E]: sel.idx = REG_AW'(addr - 8'h13);
      [8'h20:8'h23]: sel.idx = REG_AW'(addr - 8'h14);
      default:       sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

// ----- hw/rtl/swsu_in_if.sv -----
// Command channel: register write, register read or machine tick.
interface swsu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] address;
  logic [7:0] write_data;

  modport source (output valid, kind, address, write_data, input ready);
  modport sink   (input valid, kind, address, write_data, output ready);
endinterface

// ----- hw/rtl/swsu_out_if.sv -----
// Result channel: read byte and mixed audio sample.
interface swsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        sample_valid;
  logic [13:0] sample_value;

  modport source (output valid, read_data, sample_valid, sample_value, input ready);
  modport sink   (input valid, read_data, sample_valid, sample_value, output ready);
endinterface

// ----- hw/rtl/swsu_regfile.sv -----
// Register file, wave RAM, power control and trigger handling.
module swsu_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  swsu_pkg::cmd_t      cmd_i,
  output logic [7:0]          rdata_o,
  output swsu_pkg::sq_ctrl_t  sq_ctrl_o [swsu_pkg::NUM_SQ],
  output swsu_pkg::sq_mix_t   sq_mix_o  [swsu_pkg::NUM_SQ]
);

  logic [7:0] chan_q  [swsu_pkg::NUM_REGS];
  logic [7:0] chan_d  [swsu_pkg::NUM_REGS];
  logic [7:0] wave_q  [swsu_pkg::WAVE_BYTES];
  logic [7:0] wave_d  [swsu_pkg::WAVE_BYTES];
  logic [7:0] sweep_q, sweep_d;
  logic [7:0] wave_en_q, wave_en_d;
  logic [7:0] volume_q, volume_d;
  logic [7:0] panning_q, panning_d;
  logic [7:0] status_q, status_d;
  logic [swsu_pkg::NUM_SQ-1:0] trig_q, trig_d;
  swsu_pkg::chan_sel_t sel;
  logic is_wave;

  assign sel     = swsu_pkg::chan_decode(cmd_i.address);
  assign is_wave = (cmd_i.address >= swsu_pkg::ADDR_WAVE_LO) &&
                   (cmd_i.address <= swsu_pkg::ADDR_WAVE_HI);

  always_comb begin
    chan_d    = chan_q;
    wave_d    = wave_q;
    sweep_d   = sweep_q;
    wave_en_d = wave_en_q;
    volume_d  = volume_q;
    panning_d = panning_q;
    status_d  = status_q;
    trig_d    = trig_q;
    if (fire_i) begin
      case (cmd_i.kind)
        swsu_pkg::KIND_WRITE: begin
          if (is_wave) begin
            wave_d[cmd_i.address[swsu_pkg::WAVE_AW-1:0]] = cmd_i.write_data;
          end else if (cmd_i.address == swsu_pkg::ADDR_NR52) begin
            status_d = {cmd_i.write_data[7:4], status_q[3:0]};
          end else if (status_q[7]) begin
            case (cmd_i.address)
              swsu_pkg::ADDR_NR10: sweep_d   = cmd_i.write_data;
              swsu_pkg::ADDR_NR30: wave_en_d = cmd_i.write_data;
              swsu_pkg::ADDR_NR50: volume_d  = cmd_i.write_data;
              swsu_pkg::ADDR_NR51: panning_d = cmd_i.write_data;
              default: begin
                if (sel.hit) begin
                  chan_d[sel.idx] = cmd_i.write_data;
                end
                if (cmd_i.address == swsu_pkg::ADDR_NR14) begin
                  trig_d[0] = cmd_i.write_data[7];
                end
                if (cmd_i.address == swsu_pkg::ADDR_NR24) begin
                  trig_d[1] = cmd_i.write_data[7];
                end
              end
            endcase
          end
        end
        swsu_pkg::KIND_TICK: begin
          if (!status_q[7]) begin
            // drop channel state while powered down; triggers hold
            status_d[3:0] = '0;
            sweep_d       = '0;
            wave_en_d     = '0;
            volume_d      = '0;
            panning_d     = '0;
            for (int i = 0; i < swsu_pkg::NUM_REGS; i++) begin
              chan_d[i] = '0;
            end
          end else begin
            for (int c = 0; c < swsu_pkg::NUM_SQ; c++) begin
              if (trig_q[c]) begin
                status_d[c] = 1'b1;
                trig_d[c]   = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < swsu_pkg::NUM_REGS; i++) begin
        chan_q[i] <= '0;
      end
      for (int i = 0; i < swsu_pkg::WAVE_BYTES; i++) begin
        wave_q[i] <= '0;
      end
      sweep_q   <= '0;
      wave_en_q <= '0;
      volume_q  <= '0;
      panning_q <= '0;
      status_q  <= '0;
      trig_q    <= '0;
    end else begin
      chan_q    <= chan_d;
      wave_q    <= wave_d;
      sweep_q   <= sweep_d;
      wave_en_q <= wave_en_d;
      volume_q  <= volume_d;
      panning_q <= panning_d;
      status_q  <= status_d;
      trig_q    <= trig_d;
    end
  end

  // Channels clock on the status bits seen before this tick's triggers
  always_comb begin
    for (int c = 0; c < swsu_pkg::NUM_SQ; c++) begin
      sq_ctrl_o[c].step = fire_i && (cmd_i.kind == swsu_pkg::KIND_TICK) &&
                          status_q[7] && status_q[c];
      sq_ctrl_o[c].freq = {chan_q[c*4+3][2:0], chan_q[c*4+2]};
      sq_mix_o[c].on    = status_d[c];
      sq_mix_o[c].duty  = chan_d[c*4][7:6];
    end
  end

  always_comb begin
    if (is_wave) begin
      rdata_o = wave_q[cmd_i.address[swsu_pkg::WAVE_AW-1:0]];
    end else begin
      case (cmd_i.address)
        swsu_pkg::ADDR_NR10: rdata_o = sweep_q    | swsu_pkg::MASK_NR10;
        swsu_pkg::ADDR_NR30: rdata_o = wave_en_q  | swsu_pkg::MASK_NR30;
        swsu_pkg::ADDR_NR11: rdata_o = chan_q[0]  | swsu_pkg::MASK_NRX1;
        swsu_pkg::ADDR_NR21: rdata_o = chan_q[4]  | swsu_pkg::MASK_NRX1;
        swsu_pkg::ADDR_NR12: rdata_o = chan_q[1];
        swsu_pkg::ADDR_NR22: rdata_o = chan_q[5];
        swsu_pkg::ADDR_NR32: rdata_o = chan_q[9]  | swsu_pkg::MASK_NR32;
        swsu_pkg::ADDR_NR42: rdata_o = chan_q[13];
        swsu_pkg::ADDR_NR43: rdata_o = chan_q[14];
        swsu_pkg::ADDR_NR14: rdata_o = chan_q[3]  | swsu_pkg::MASK_NRX4;
        swsu_pkg::ADDR_NR24: rdata_o = chan_q[7]  | swsu_pkg::MASK_NRX4;
        swsu_pkg::ADDR_NR34: rdata_o = chan_q[11] | swsu_pkg::MASK_NRX4;
        swsu_pkg::ADDR_NR44: rdata_o = chan_q[15] | swsu_pkg::MASK_NRX4;
        swsu_pkg::ADDR_NR50: rdata_o = volume_q;
        swsu_pkg::ADDR_NR51: rdata_o = panning_q;
        swsu_pkg::ADDR_NR52: rdata_o = status_q   | swsu_pkg::MASK_NR52;
        default:             rdata_o = swsu_pkg::READ_UNMAP;
      endcase
    end
  end

endmodule

// ----- hw/rtl/swsu_square.sv -----
// One square channel: period counter and duty position.
module swsu_square (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swsu_pkg::sq_ctrl_t ctrl_i,
  output logic [2:0]         pos_next_o
);

  logic [swsu_pkg::FREQ_W-1:0] count_q, count_d;
  logic [2:0]                  pos_q, pos_d;

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (ctrl_i.step) begin
      if (count_q == swsu_pkg::PERIOD_TOP) begin
        count_d = ctrl_i.freq;
        pos_d   = pos_q + 3'd1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  assign pos_next_o = pos_d;

endmodule

// ----- hw/rtl/square_wave_sound_unit.sv -----
// Top level of the square wave sound unit: input stage, sample timer, mixer, result stage.
// A transaction accepted into the input register moves on to the result register when that is free.
// Throughput: one transaction per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: asynchronous, active low; clears the register file, wave RAM, counters, phase and
// valid flags, sample period 23; the command and result data registers are not reset.
module square_wave_sound_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  swsu_in_if.sink    in_i,
  swsu_out_if.source out_o
);

  swsu_pkg::cmd_t cmd_q;
  logic           cmd_vld_q;
  logic           out_vld_q;
  logic           out_free;
  logic           fire;

  logic [7:0] sample_period_q;
  logic [7:0] phase_q, phase_d;
  logic       emit;

  logic [7:0]                   rdata;
  logic [7:0]                   read_data_q;
  logic                         sample_valid_q;
  logic [swsu_pkg::LEVEL_W-1:0] sample_value_q, sample_value_d;

  swsu_pkg::sq_ctrl_t sq_ctrl [swsu_pkg::NUM_SQ];
  swsu_pkg::sq_mix_t  sq_mix  [swsu_pkg::NUM_SQ];
  logic [2:0]         pos_next [swsu_pkg::NUM_SQ];
  logic [swsu_pkg::NUM_SQ-1:0] level;

  assign out_free   = !out_vld_q || out_o.ready;
  assign fire       = cmd_vld_q && out_free;
  assign in_i.ready = !cmd_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      cmd_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q <= '{kind: in_i.kind, address: in_i.address, write_data: in_i.write_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= swsu_pkg::SAMPLE_PERIOD_RST;
    end else if (cfg_we_i) begin
      sample_period_q <= cfg_wdata_i;
    end
  end

  swsu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cmd_i     (cmd_q),
    .rdata_o   (rdata),
    .sq_ctrl_o (sq_ctrl),
    .sq_mix_o  (sq_mix)
  );

  for (genvar c = 0; c < swsu_pkg::NUM_SQ; c++) begin : g_sq
    swsu_square u_square (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (sq_ctrl[c]),
      .pos_next_o (pos_next[c])
    );
    assign level[c] = sq_mix[c].on && swsu_pkg::duty_bit(sq_mix[c].duty, pos_next[c]);
  end

  // Emit when the advanced phase reaches the period; a zero period acts as one
  always_comb begin
    emit    = 1'b0;
    phase_d = phase_q;
    if (fire && (cmd_q.kind == swsu_pkg::KIND_TICK)) begin
      if ({1'b0, phase_q} + 9'd1 >= {1'b0, sample_period_q}) begin
        emit    = 1'b1;
        phase_d = '0;
      end else begin
        phase_d = phase_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    case (level)
      2'b00:   sample_value_d = '0;
      2'b11:   sample_value_d = swsu_pkg::LEVEL_FULL;
      default: sample_value_d = swsu_pkg::LEVEL_HALF;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_data_q    <= (cmd_q.kind == swsu_pkg::KIND_READ) ? rdata : 8'h00;
      sample_valid_q <= emit;
      sample_value_q <= emit ? sample_value_d : '0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.read_data    = read_data_q;
  assign out_o.sample_valid = sample_valid_q;
  assign out_o.sample_value = sample_value_q;

`ifndef ASSERT_OFF
  a_stall_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_vld_q && !out_free |=> cmd_vld_q && $stable(cmd_q))
    else $error("input stage lost a stalled transaction");

  a_sample_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sample_valid_q |-> (sample_value_q == '0) ||
      (sample_value_q == swsu_pkg::LEVEL_HALF) || (sample_value_q == swsu_pkg::LEVEL_FULL))
    else $error("sample value off the mixer levels");

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !sample_valid_q |-> sample_value_q == '0)
    else $error("sample value set without a sample");

  a_sample_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sample_valid_q |-> read_data_q == 8'h00)
    else $error("read data set on a tick result");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the square wave sound unit: register map, duty stepping and mixing.
module tb;
  import swsu_pkg::*;

  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam logic [7:0]  ADDR_NR13    = 8'h13;
  localparam logic [7:0]  ADDR_NR20    = 8'h15;
  localparam logic [7:0]  ADDR_NR23    = 8'h18;
  localparam logic [7:0]  ADDR_LAST    = 8'hFF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned OPENING_LEN  = 25;
  // Bit n of each row is the channel level at duty position n
  localparam logic [7:0]  SQ_WAVE [4]  = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

  typedef struct packed {
    logic [7:0]         rd;
    logic               sv;
    logic [LEVEL_W-1:0] level;
  } reply_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] data;
    logic       known;
    logic [7:0] rd;
  } probe_t;

  localparam probe_t OPENING [OPENING_LEN] = '{
    '{KIND_READ,  ADDR_NR52,    8'h00, 1'b1, 8'h70},
    '{KIND_READ,  ADDR_NR10,    8'h00, 1'b1, 8'h80},
    '{KIND_READ,  ADDR_LAST,    8'hFF, 1'b1, 8'hFF},
    '{KIND_WRITE, ADDR_NR11,    8'hC0, 1'b0, 8'h00},
    '{KIND_READ,  ADDR_NR11,    8'h00, 1'b1, 8'h3F},
    '{KIND_WRITE, ADDR_WAVE_HI, 8'hA5, 1'b0, 8'h00},
    '{KIND_READ,  ADDR_WAVE_HI, 8'h00, 1'b1, 8'hA5},
    '{KIND_READ,  ADDR_WAVE_LO, 8'h00, 1'b1, 8'h00},
    '{KIND_WRITE, ADDR_NR52,    8'hFF, 1'b0, 8'h00},
    '{KIND_READ,  ADDR_NR52,    8'h00, 1'b1, 8'hF0},
    '{KIND_WRITE, ADDR_NR11,    8'hC0, 1'b0, 8'h00},
    '{KIND_WRITE, ADDR_NR13,    8'hFF, 1'b0, 8'h00},
    '{KIND_WRITE, ADDR_NR14,    8'h87, 1'b0, 8'h00},
    '{KIND_WRITE, ADDR_NR24,    8'h80, 1'b0, 8'h00},
    '{KIND_WRITE, ADDR_NR24,    8'h00, 1'b0, 8'h00},
    '{KIND_TICK,  ADDR_NR10,    8'h00, 1'b0, 8'h00},
    '{KIND_READ,  ADDR_NR52,    8'h00, 1'b1, 8'hF1},
    '{KIND_READ,  ADDR_NR14,    8'h00, 1'b1, 8'hBF},
    '{KIND_READ,  ADDR_NR13,    8'h00, 1'b1, 8'hFF},
    '{KIND_READ,  ADDR_NR20,    8'h00, 1'b1, 8'hFF},
    '{KIND_SPARE, ADDR_LAST,    8'hFF, 1'b1, 8'h00},
    '{KIND_WRITE, ADDR_NR52,    8'h00, 1'b0, 8'h00},
    '{KIND_TICK,  ADDR_NR10,    8'h00, 1'b0, 8'h00},
    '{KIND_READ,  ADDR_NR11,    8'h00, 1'b1, 8'h3F},
    '{KIND_READ,  ADDR_NR52,    8'h00, 1'b1, 8'h70}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  swsu_in_if  cmd_ch ();
  swsu_out_if reply_ch ();

  square_wave_sound_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_ch),
    .out_o       (reply_ch)
  );

  // Shadow copy of the sound unit
  logic [7:0]        chan_reg [NUM_REGS];
  logic [7:0]        wave_mem [WAVE_BYTES];
  logic [7:0]        nr10_q, nr30_q, nr50_q, nr51_q, nr52_q;
  logic [FREQ_W-1:0] period_ctr [NUM_SQ];
  logic [2:0]        duty_pos [NUM_SQ];
  logic              trig_pend [NUM_SQ];
  logic [7:0]        tick_phase;
  logic [7:0]        ticks_per_sample;

  reply_t      expected_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] read_byte(input logic [7:0] addr);
    if (addr >= ADDR_WAVE_LO && addr <= ADDR_WAVE_HI) return wave_mem[addr[WAVE_AW-1:0]];
    case (addr)
      ADDR_NR10: return nr10_q | MASK_NR10;
      ADDR_NR30: return nr30_q | MASK_NR30;
      ADDR_NR11: return chan_reg[0] | MASK_NRX1;
      ADDR_NR21: return chan_reg[4] | MASK_NRX1;
      ADDR_NR12: return chan_reg[1];
      ADDR_NR22: return chan_reg[5];
      ADDR_NR32: return chan_reg[9] | MASK_NR32;
      ADDR_NR42: return chan_reg[13];
      ADDR_NR43: return chan_reg[14];
      ADDR_NR14: return chan_reg[3] | MASK_NRX4;
      ADDR_NR24: return chan_reg[7] | MASK_NRX4;
      ADDR_NR34: return chan_reg[11] | MASK_NRX4;
      ADDR_NR44: return chan_reg[15] | MASK_NRX4;
      ADDR_NR50: return nr50_q;
      ADDR_NR51: return nr51_q;
      ADDR_NR52: return nr52_q | MASK_NR52;
      default:   return READ_UNMAP;
    endcase
  endfunction

  task automatic store_byte(input logic [7:0] addr, input logic [7:0] data);
    int unsigned off, ch, slot;
    if (addr >= ADDR_WAVE_LO && addr <= ADDR_WAVE_HI) begin
      wave_mem[addr[WAVE_AW-1:0]] = data;
    end else if (addr == ADDR_NR52) begin
      nr52_q = {data[7:4], nr52_q[3:0]};
    end else if (nr52_q[7]) begin
      case (addr)
        ADDR_NR10: nr10_q = data;
        ADDR_NR30: nr30_q = data;
        ADDR_NR50: nr50_q = data;
        ADDR_NR51: nr51_q = data;
        default: begin
          if (addr > ADDR_NR10 && addr <= ADDR_NR44) begin
            off  = 32'(addr - ADDR_NR10);
            ch   = off / 5;
            slot = off % 5;
            // every fifth address is a hole in the channel map
            if (slot != 0) begin
              chan_reg[ch * 4 + slot - 1] = data;
              if (slot == 4 && ch < NUM_SQ) trig_pend[ch] = data[7];
            end
          end
        end
      endcase
    end
  endtask

  task automatic step_tick(output reply_t r);
    logic [FREQ_W-1:0] freq;
    int unsigned       ch, lit;
    r = '0;
    if (!nr52_q[7]) begin
      // power off: wipe the register file, hold counters and pending triggers
      nr52_q[3:0] = '0;
      nr10_q = '0;
      nr30_q = '0;
      nr50_q = '0;
      nr51_q = '0;
      foreach (chan_reg[i]) chan_reg[i] = '0;
    end else begin
      for (ch = 0; ch < NUM_SQ; ch++) begin
        if (nr52_q[ch]) begin
          freq = {chan_reg[ch * 4 + 3][2:0], chan_reg[ch * 4 + 2]};
          if (period_ctr[ch] == PERIOD_TOP) begin
            period_ctr[ch] = freq;
            duty_pos[ch]   = duty_pos[ch] + 3'd1;
          end else begin
            period_ctr[ch] = period_ctr[ch] + 1'b1;
          end
        end
      end
      for (ch = 0; ch < NUM_SQ; ch++) begin
        if (trig_pend[ch]) begin
          nr52_q[ch]    = 1'b1;
          trig_pend[ch] = 1'b0;
        end
      end
    end
    if (int'(tick_phase) + 1 >= int'(ticks_per_sample)) begin
      tick_phase = '0;
      r.sv = 1'b1;
      lit = 0;
      for (ch = 0; ch < NUM_SQ; ch++) begin
        if (nr52_q[ch] && SQ_WAVE[chan_reg[ch * 4][7:6]][duty_pos[ch]]) lit++;
      end
      r.level = (lit == 2) ? LEVEL_FULL : (lit == 1) ? LEVEL_HALF : '0;
    end else begin
      tick_phase = tick_phase + 8'd1;
    end
  endtask

  task automatic apply_cmd(input logic [1:0] kind, input logic [7:0] addr,
                           input logic [7:0] data, output reply_t r);
    r = '0;
    case (kind)
      KIND_WRITE: store_byte(addr, data);
      KIND_READ:  r.rd = read_byte(addr);
      KIND_TICK:  step_tick(r);
      default:    r = '0;
    endcase
  endtask

  task automatic issue(input logic [1:0] kind, input logic [7:0] addr, input logic [7:0] data,
                       input logic known, input logic [7:0] known_rd);
    reply_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= kind;
    cmd_ch.address    <= addr;
    cmd_ch.write_data <= data;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    apply_cmd(kind, addr, data, r);
    if (known) r = '{rd: known_rd, sv: 1'b0, level: '0};
    expected_replies.push_back(r);
    items_sent++;
  endtask

  task automatic poke(input logic [7:0] addr, input logic [7:0] data);
    issue(KIND_WRITE, addr, data, 1'b0, 8'h00);
  endtask

  task automatic peek(input logic [7:0] addr);
    issue(KIND_READ, addr, 8'($urandom), 1'b0, 8'h00);
  endtask

  task automatic tick_once();
    issue(KIND_TICK, 8'($urandom), 8'($urandom), 1'b0, 8'h00);
  endtask

  function automatic logic [7:0] mapped_addr();
    return 8'($urandom_range(ADDR_NR10, ADDR_WAVE_HI));
  endfunction

  // Drop valid, wait out every pending transaction and the pipeline behind it
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_period(input logic [7:0] p);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ticks_per_sample = p;
  endtask

  // Power up, program one or both square channels, usually trigger them and let them run
  task automatic play_note();
    int unsigned sel, ch, n;
    logic [7:0]  nrx4;
    sel = $urandom_range(1, 3);
    poke(ADDR_NR52, {1'b1, 7'($urandom)});
    for (ch = 0; ch < NUM_SQ; ch++) begin
      if (sel[ch]) begin
        poke(ch ? ADDR_NR21 : ADDR_NR11, 8'($urandom));
        poke(ch ? ADDR_NR23 : ADDR_NR13, 8'($urandom));
        nrx4 = 8'($urandom);
        // mostly trigger with a high frequency so the duty pattern steps often
        if ($urandom_range(0, 7) != 0) nrx4[7] = 1'b1;
        if ($urandom_range(0, 3) != 0) nrx4[2:0] = 3'b111;
        poke(ch ? ADDR_NR24 : ADDR_NR14, nrx4);
      end
    end
    if ($urandom_range(0, 2) == 0) poke(mapped_addr(), 8'($urandom));
    n = $urandom_range(4, 40);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) peek(mapped_addr());
      tick_once();
    end
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned stop;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: play_note();
        6, 7: begin
          repeat ($urandom_range(1, 6)) begin
            issue(2'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) : mapped_addr(),
                  8'($urandom), 1'b0, 8'h00);
          end
        end
        8: begin
          repeat ($urandom_range(2, 8)) peek(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                       : mapped_addr());
        end
        default: begin
          // power off in the middle of a note; an NR14 write that may follow is dropped
          poke(ADDR_NR52, {1'b0, 7'($urandom)});
          if ($urandom_range(0, 1) == 0) poke(ADDR_NR14, 8'($urandom));
          repeat ($urandom_range(1, 6)) tick_once();
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= 8'h00;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.kind       <= KIND_WRITE;
    cmd_ch.address    <= 8'h00;
    cmd_ch.write_data <= 8'h00;
    foreach (chan_reg[i]) chan_reg[i] = '0;
    foreach (wave_mem[i]) wave_mem[i] = '0;
    nr10_q = '0;
    nr30_q = '0;
    nr50_q = '0;
    nr51_q = '0;
    nr52_q = '0;
    foreach (period_ctr[i]) begin
      period_ctr[i] = '0;
      duty_pos[i]   = '0;
      trig_pend[i]  = 1'b0;
    end
    tick_phase       = '0;
    ticks_per_sample = SAMPLE_PERIOD_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < OPENING_LEN; k++) begin
      issue(OPENING[k].kind, OPENING[k].addr, OPENING[k].data, OPENING[k].known, OPENING[k].rd);
    end

    set_period(SAMPLE_PERIOD_RST);
    // bring both channels up with fixed duty settings and let them count
    poke(ADDR_NR52, 8'h80);
    poke(ADDR_NR11, 8'h80);
    poke(ADDR_NR21, 8'h40);
    poke(ADDR_NR13, 8'hF8);
    poke(ADDR_NR23, 8'hFC);
    poke(ADDR_NR14, 8'h87);
    poke(ADDR_NR24, 8'h87);
    repeat (60) tick_once();
    run_phase(60);

    set_period(8'd255);
    run_phase(50);
    set_period(8'd1);
    run_phase(50);
    set_period(8'($urandom_range(2, 9)));
    run_phase(50);
    set_period(8'd255);
    run_phase(40);
    set_period(8'($urandom_range(1, 255)));
    run_phase(50);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_period(8'd2);
    run_phase(50);

    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : sink_pacing
    reply_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      reply_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : score
    reply_t want;
    if (rst_ni && reply_ch.valid && reply_ch.ready) begin
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: reply with none pending, actual rd=%h sample=%b level=%0d", $time,
                 reply_ch.read_data, reply_ch.sample_valid, reply_ch.sample_value);
      end else begin
        want = expected_replies.pop_front();
        if (reply_ch.read_data !== want.rd) begin
          mismatch_count++;
          $display("%0t: read_data expected %h actual %h", $time, want.rd, reply_ch.read_data);
        end
        if (reply_ch.sample_valid !== want.sv) begin
          mismatch_count++;
          $display("%0t: sample_valid expected %b actual %b", $time, want.sv,
                   reply_ch.sample_valid);
        end
        if (reply_ch.sample_value !== want.level) begin
          mismatch_count++;
          $display("%0t: sample_value expected %0d actual %0d", $time, want.level,
                   reply_ch.sample_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/swsu_pkg.sv
hw/rtl/swsu_in_if.sv
hw/rtl/swsu_out_if.sv
hw/rtl/swsu_regfile.sv
hw/rtl/swsu_square.sv
hw/rtl/square_wave_sound_unit.sv
dv/tb.sv
